// ----- rtl/mkbw_pkg.sv -----
// ----------------------------------------------------------------------------
// mkbw_pkg
// Shared widths, constants and types of the modified Kaiser-Bessel window.
// ----------------------------------------------------------------------------
package mkbw_pkg;

  localparam int DATA_W   = 32;
  localparam int QUOT_W   = 31;
  localparam int NUM_COEF = 12;

  localparam logic [DATA_W-1:0] WIDTH_RESET = 32'd65536;
  localparam logic [DATA_W-1:0] ONE_Q31     = 32'h8000_0000;

  // c1 .. c12 in unsigned Q1.31, index 0 holds c1
  localparam logic [DATA_W-1:0] COEF [NUM_COEF] = '{
    32'd89018979,
    32'd343196137,
    32'd588057310,
    32'd566786428,
    32'd349622364,
    32'd149767119,
    32'd47134637,
    32'd11357427,
    32'd2162294,
    32'd333453,
    32'd42498,
    32'd4551
  };

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

// ----- rtl/mkbw_div.sv -----
// ----------------------------------------------------------------------------
// mkbw_div
// Pipelined restoring divider, one quotient bit per stage, forming
// r = floor(rem * 2^QUOT_W / divisor) for rem below divisor.
// ----------------------------------------------------------------------------
module mkbw_div
  import mkbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ctl_t              in_ctl,
  input  logic [DATA_W-1:0] in_rem,
  input  logic [DATA_W-1:0] divisor,
  output ctl_t              out_ctl,
  output logic [QUOT_W-1:0] out_quot
);

  ctl_t              ctl_r  [QUOT_W];
  logic [DATA_W-1:0] rem_r  [QUOT_W];
  logic [QUOT_W-1:0] quot_r [QUOT_W];

  for (genvar g = 0; g < QUOT_W; g++) begin : g_step
    ctl_t              ctl_in;
    logic [DATA_W-1:0] rem_in;
    logic [QUOT_W-1:0] quot_in;
    logic [DATA_W:0]   dbl;
    logic [DATA_W:0]   diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign ctl_in  = in_ctl;
      assign rem_in  = in_rem;
      assign quot_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quot_in = quot_r[g-1];
    end

    assign dbl  = {rem_in, 1'b0};
    assign diff = dbl - {1'b0, divisor};
    assign ge   = (dbl >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[g].valid <= ctl_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[g].zero <= ctl_in.zero;
        rem_r[g]      <= ge ? diff[DATA_W-1:0] : dbl[DATA_W-1:0];
        quot_r[g]     <= {quot_in[QUOT_W-2:0], ge};
      end
    end
  end

  assign out_ctl  = ctl_r[QUOT_W-1];
  assign out_quot = quot_r[QUOT_W-1];

endmodule

// ----- rtl/mkbw_horner.sv -----
// ----------------------------------------------------------------------------
// mkbw_horner
// Squares r into arg = 1 - r^2, then runs the Horner polynomial in arg,
// one multiply-add per stage, and forces zero outside the window.
// ----------------------------------------------------------------------------
module mkbw_horner
  import mkbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ctl_t              in_ctl,
  input  logic [QUOT_W-1:0] in_r,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_value
);

  ctl_t                sq_ctl_r;
  logic [DATA_W-1:0]   sq_arg_r;
  logic [2*QUOT_W-1:0] sq_prod;

  ctl_t              h_ctl_r [NUM_COEF-1];
  logic [DATA_W-1:0] h_arg_r [NUM_COEF-1];
  logic [DATA_W-1:0] h_acc_r [NUM_COEF-1];
  logic              fin_valid_r;
  logic [DATA_W-1:0] fin_value_r;

  assign sq_prod = {{QUOT_W{1'b0}}, in_r} * {{QUOT_W{1'b0}}, in_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      sq_ctl_r.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctl_r.zero <= in_ctl.zero;
      sq_arg_r      <= ONE_Q31 - {1'b0, sq_prod[2*QUOT_W-1:QUOT_W]};
    end
  end

  for (genvar g = 0; g < NUM_COEF; g++) begin : g_step
    ctl_t                ctl_in;
    logic [DATA_W-1:0]   arg_in;
    logic [DATA_W-1:0]   acc_in;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   scaled;

    if (g == 0) begin : g_first
      assign ctl_in = sq_ctl_r;
      assign arg_in = sq_arg_r;
      assign acc_in = COEF[NUM_COEF-1];
    end else begin : g_next
      assign ctl_in = h_ctl_r[g-1];
      assign arg_in = h_arg_r[g-1];
      assign acc_in = h_acc_r[g-1];
    end

    assign prod   = {{DATA_W{1'b0}}, acc_in} * {{DATA_W{1'b0}}, arg_in};
    assign scaled = prod[2*DATA_W-2:DATA_W-1];

    if (g < NUM_COEF-1) begin : g_mid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          h_ctl_r[g].valid <= 1'b0;
        end else if (adv) begin
          h_ctl_r[g].valid <= ctl_in.valid;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          h_ctl_r[g].zero <= ctl_in.zero;
          h_arg_r[g]      <= arg_in;
          h_acc_r[g]      <= scaled + COEF[NUM_COEF-2-g];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fin_valid_r <= 1'b0;
        end else if (adv) begin
          fin_valid_r <= ctl_in.valid;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          fin_value_r <= ctl_in.zero ? '0 : scaled;
        end
      end
    end
  end

  assign out_valid = fin_valid_r;
  assign out_value = fin_value_r;

endmodule

// ----- rtl/modified_kaiser_bessel_window.sv -----
// ----------------------------------------------------------------------------
// modified_kaiser_bessel_window
// Modified Kaiser-Bessel window (alpha 2.5 pi), one signed offset per item.
//
// Usage:
//   in_*   : offset items, in_tdata is the two's complement offset.
//   out_*  : window weights, unsigned Q1.31 where 2^31 means 1.0.
//   cfg_*  : full window width; write only while no item is in flight.
//   Offsets with 2|x| >= width, and every offset at zero width, give zero.
// Throughput: one item per cycle, sustained while the output is taken.
// Pipeline: 45 register stages: one input stage, 31 divider stages (one
//   quotient bit each), one squaring stage and twelve Horner stages (a
//   32x32 multiply-add each but a final 32x32 multiply), the last being
//   the output register.
// Stall: all stages advance together when the output register is empty or
//   taken; in_tready drops while the output holds an item not taken.
// Reset: clears all valid bits and loads a width of 65536.
// ----------------------------------------------------------------------------
module modified_kaiser_bessel_window
  import mkbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,    // [31:0] offset
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,   // [31:0] window_value
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  logic              adv;
  logic [DATA_W-1:0] window_width_r;
  logic [DATA_W-1:0] mag;
  logic [DATA_W:0]   mag2;
  logic              in_window;
  ctl_t              s0_ctl_r;
  logic [DATA_W-1:0] s0_rem_r;
  ctl_t              div_ctl;
  logic [QUOT_W-1:0] div_quot;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign mag       = in_tdata[DATA_W-1] ? (~in_tdata + DATA_W'(1)) : in_tdata;
  assign mag2      = {mag, 1'b0};
  assign in_window = (window_width_r != '0) && (mag2 < {1'b0, window_width_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_width_r <= WIDTH_RESET;
      s0_ctl_r.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_width_r <= cfg_wr_data;
      end
      if (adv) begin
        s0_ctl_r.valid <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r.zero <= !in_window;
      s0_rem_r      <= mag2[DATA_W-1:0];
    end
  end

  mkbw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (s0_ctl_r),
    .in_rem   (s0_rem_r),
    .divisor  (window_width_r),
    .out_ctl  (div_ctl),
    .out_quot (div_quot)
  );

  mkbw_horner u_horner (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_ctl    (div_ctl),
    .in_r      (div_quot),
    .out_valid (out_tvalid),
    .out_value (out_tdata)
  );

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= ONE_Q31)
    else $error("window value above 1.0");

  a_div_pre: assert property (@(posedge clk) disable iff (!rst_n)
    s0_ctl_r.valid && !s0_ctl_r.zero |-> s0_rem_r < window_width_r)
    else $error("divider remainder not below width");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s0_ctl_r.valid)
    else $error("accepted item lost at input stage");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modified Kaiser-Bessel window (alpha 2.5 pi).
// A short stimulus table covers the center, the window edge, the most
// negative offset and zero, one and full-scale widths. Random phases follow,
// each with a new width, offsets mostly inside the window and random gaps on
// both streams. Every weight is checked in order, against its typed table
// weight or else an integer Q1.31 Horner evaluation held in the bench.
// ----------------------------------------------------------------------------
module tb;
  import mkbw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DATA_W-1:0] CENTER_WEIGHT = 32'd2147483197;
  localparam int                PHASES        = 20;
  localparam int                PHASE_ITEMS   = 76;
  localparam int                HOLD_CYCLES   = 300;
  localparam int                FLUSH_CYCLES  = 60;

  localparam logic [63:0] KB_TAPS [12] = '{
    64'd89018979, 64'd343196137, 64'd588057310, 64'd566786428,
    64'd349622364, 64'd149767119, 64'd47134637, 64'd11357427,
    64'd2162294, 64'd333453, 64'd42498, 64'd4551
  };

  typedef struct packed {
    logic [DATA_W-1:0] width;
    logic [DATA_W-1:0] offset;
    logic              typed;
    logic [DATA_W-1:0] weight;
  } vec_t;

  localparam int NUM_VECS = 23;

  localparam vec_t VECS [NUM_VECS] = '{
    '{32'd65536,      32'd0,          1'b1, CENTER_WEIGHT},
    '{32'd65536,      32'd32768,      1'b1, 32'd0},
    '{32'd65536,      -32'sd32768,    1'b1, 32'd0},
    '{32'd65536,      32'd32767,      1'b0, 32'd0},
    '{32'd65536,      32'hFFFF_FFFF,  1'b0, 32'd0},
    '{32'd65536,      32'h8000_0000,  1'b1, 32'd0},
    '{32'd65536,      32'h7FFF_FFFF,  1'b1, 32'd0},
    '{32'd65536,      32'd12345,      1'b0, 32'd0},
    '{32'd0,          32'd0,          1'b1, 32'd0},
    '{32'd0,          -32'sd5,        1'b1, 32'd0},
    '{32'd0,          32'h7FFF_FFFF,  1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'd0,          1'b1, CENTER_WEIGHT},
    '{32'hFFFF_FFFF,  32'h7FFF_FFFF,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'h8000_0000,  1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'h8000_0001,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'h4000_0000,  1'b0, 32'd0},
    '{32'd1,          32'd0,          1'b1, CENTER_WEIGHT},
    '{32'd1,          32'd1,          1'b1, 32'd0},
    '{32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
    '{32'd2,          32'd0,          1'b1, CENTER_WEIGHT},
    '{32'd2,          32'd1,          1'b1, 32'd0},
    '{32'd3,          32'd1,          1'b0, 32'd0},
    '{32'd3,          32'hFFFF_FFFF,  1'b0, 32'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;    // [31:0] offset
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;   // [31:0] window_value
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  logic [DATA_W-1:0] weight_q [$];
  logic [DATA_W-1:0] width_now;
  int                mismatches;
  int                hold_requests;
  int                holds_done;
  bit                tx_quiet;
  bit                rx_quiet;

  modified_kaiser_bessel_window dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] kb_weight(input logic [DATA_W-1:0] width,
                                                  input logic [DATA_W-1:0] offset);
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] arg;
    logic [63:0] acc;
    if (width == '0) return '0;
    mag = offset[DATA_W-1] ? (64'h1_0000_0000 - {32'd0, offset}) : {32'd0, offset};
    if ((mag << 1) >= {32'd0, width}) return '0;
    r   = (mag << 32) / {32'd0, width};
    r2  = (r * r) >> 31;
    arg = 64'h8000_0000 - r2;
    acc = KB_TAPS[11];
    for (int k = 10; k >= 0; k--) acc = ((acc * arg) >> 31) + KB_TAPS[k];
    acc = (acc * arg) >> 31;
    return acc[DATA_W-1:0];
  endfunction

  // call at a falling edge; returns at a falling edge after the item is taken
  task automatic send_offset(input logic [DATA_W-1:0] offset,
                             input logic [DATA_W-1:0] weight);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= offset;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    weight_q.push_back(weight);
    @(negedge clk);
  endtask

  task automatic drain_and_set_width(input logic [DATA_W-1:0] width);
    in_tvalid <= 1'b0;
    while (weight_q.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= width;
    width_now = width;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 4);
      3:       return $urandom_range(5, 200);
      4:       return 32'd65536;
      5:       return 32'd1 << $urandom_range(0, 31);
      6:       return $urandom_range(1000, 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset(input logic [DATA_W-1:0] width);
    logic [DATA_W-1:0] max_mag;
    logic [DATA_W-1:0] mag;
    int                sel;
    sel = $urandom_range(0, 9);
    if (width == '0 || sel >= 8) return $urandom;
    max_mag = (width - 1) >> 1;
    if (sel == 7) mag = max_mag + $urandom_range(0, 1);
    else          mag = $urandom_range(0, max_mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected weight %0d at %0t", out_tdata, $realtime);
      end else begin
        want = weight_q.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("window_value: expected %0d, got %0d at %0t",
                     want, out_tdata, $realtime);
        end
      end
    end
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] off;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    width_now   = WIDTH_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (VECS[i]) begin
      if (VECS[i].width != width_now) drain_and_set_width(VECS[i].width);
      send_offset(VECS[i].offset, VECS[i].typed ? VECS[i].weight
                                                : kb_weight(width_now, VECS[i].offset));
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_and_set_width(pick_width());
      if (p == 2) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_requests++;
      end else begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        off = pick_offset(width_now);
        send_offset(off, kb_weight(width_now, off));
      end
    end

    in_tvalid <= 1'b0;
    while (weight_q.size() != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
    if (mismatches == 0 && weight_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
